// ===== rtl/core/utf8_string_validator_assert.svh =====
// ---------------------------------------------------------------------------
// UTF-8 string validator assertion macros
// Shared concurrent assertion forms used by the RTL of the validator.
// ---------------------------------------------------------------------------
`ifndef UTF8_STRING_VALIDATOR_ASSERT_SVH
`define UTF8_STRING_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define USV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/usv_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 string validator package
// Widths, constants, register codes and shared types of the validator.
// ---------------------------------------------------------------------------
`default_nettype none

package usv_pkg;

   localparam int COUNT_WIDTH = 20;
   localparam int LEN_WIDTH   = 20;
   localparam int BYTE_WIDTH  = 8;
   localparam int CP_WIDTH    = 21;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = 4;
   localparam int WIDE_WIDTH  = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;

   localparam logic [LEN_WIDTH-1:0] MAX_LENGTH_RESET = LEN_WIDTH'(128);

   localparam logic [BYTE_WIDTH-1:0] LEAD2_LO   = 8'hc2;
   localparam logic [BYTE_WIDTH-1:0] LEAD2_HI   = 8'hdf;
   localparam logic [BYTE_WIDTH-1:0] LEAD3_LO   = 8'he0;
   localparam logic [BYTE_WIDTH-1:0] LEAD3_HI   = 8'hef;
   localparam logic [BYTE_WIDTH-1:0] LEAD4_LO   = 8'hf0;
   localparam logic [BYTE_WIDTH-1:0] LEAD4_HI   = 8'hf4;
   localparam logic [BYTE_WIDTH-1:0] ASCII_TOP  = 8'h80;
   localparam logic [BYTE_WIDTH-1:0] CONTROL_HI = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] DEL_CODE   = 8'h7f;

   localparam logic [CP_WIDTH-1:0] MIN_TWO       = 21'h00080;
   localparam logic [CP_WIDTH-1:0] MIN_THREE     = 21'h00800;
   localparam logic [CP_WIDTH-1:0] MIN_FOUR      = 21'h10000;
   localparam logic [CP_WIDTH-1:0] CP_MAX        = 21'h10ffff;
   localparam logic [CP_WIDTH-1:0] SURROGATE_LO  = 21'h0d800;
   localparam logic [CP_WIDTH-1:0] SURROGATE_HI  = 21'h0dfff;

   typedef enum logic [1:0] {
      REG_REJECT_CONTROLS = 2'd0,
      REG_REJECT_NUL      = 2'd1,
      REG_MAX_LENGTH      = 2'd2
   } usv_reg_type;

   typedef enum logic [1:0] {
      CLASS_TWO   = 2'd0,
      CLASS_THREE = 2'd1,
      CLASS_FOUR  = 2'd2
   } usv_class_type;

   typedef struct packed {
      logic                 reject_controls;
      logic                 reject_nul;
      logic [LEN_WIDTH-1:0] max_length;
   } usv_cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/usv_if.sv =====
// ---------------------------------------------------------------------------
// UTF-8 string validator channels
// Valid/ready channels for the byte stream and for the string verdicts.
// ---------------------------------------------------------------------------
`default_nettype none

interface usv_req_if;
   logic                            valid;
   logic                            ready;
   logic [usv_pkg::BYTE_WIDTH-1:0]  data_byte;
   logic                            last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface usv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            string_valid;
   logic [usv_pkg::LEN_WIDTH-1:0]   string_length;

   modport source (output valid, output string_valid, output string_length, input ready);
   modport sink   (input valid, input string_valid, input string_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/usv_csr.sv =====
// ---------------------------------------------------------------------------
// UTF-8 string validator registers
// APB-style register file holding the validation policies.
// ---------------------------------------------------------------------------
`default_nettype none

module usv_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [usv_pkg::ADDR_WIDTH-1:0] paddr,
   input  wire logic [usv_pkg::DATA_WIDTH-1:0] pwdata,
   output      logic [usv_pkg::DATA_WIDTH-1:0] prdata,
   output      logic                           pready,
   output      usv_pkg::usv_cfg_type           cfg
);
   import usv_pkg::*;

   usv_cfg_type cfg_ff;
   usv_cfg_type cfg_in;
   logic        write_en;
   usv_reg_type reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;
   assign reg_sel  = usv_reg_type'(paddr[ADDR_WIDTH-1:2]);
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (reg_sel)
         REG_REJECT_CONTROLS: begin
            prdata = DATA_WIDTH'(cfg_ff.reject_controls);
            if (write_en) begin
               cfg_in.reject_controls = pwdata[0];
            end
         end
         REG_REJECT_NUL: begin
            prdata = DATA_WIDTH'(cfg_ff.reject_nul);
            if (write_en) begin
               cfg_in.reject_nul = pwdata[0];
            end
         end
         REG_MAX_LENGTH: begin
            prdata = DATA_WIDTH'(cfg_ff.max_length);
            if (write_en) begin
               cfg_in.max_length = pwdata[LEN_WIDTH-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reject_controls <= 1'b0;
         cfg_ff.reject_nul      <= 1'b0;
         cfg_ff.max_length      <= MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_string_validator.sv =====
// A last byte's verdict passes the input stage register, then the result register.
// Throughput: one byte per cycle unless a last byte waits behind an untaken verdict.
// A verdict waiting in the result register does not stop bytes without the last mark.
// Reset is synchronous and active high; it clears the string state, both valid flags
// and the policy registers, and the block takes bytes in the cycle after reset falls.
// ---------------------------------------------------------------------------
// UTF-8 string validator
// Checks strict UTF-8 and the length and byte policies of a byte stream and
// gives one verdict per string on its last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_string_validator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   usv_req_if.sink                             req_if,
   usv_rsp_if.source                           rsp_if,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [usv_pkg::ADDR_WIDTH-1:0] paddr,
   input  wire logic [usv_pkg::DATA_WIDTH-1:0] pwdata,
   output      logic [usv_pkg::DATA_WIDTH-1:0] prdata,
   output      logic                           pready
);
   import usv_pkg::*;

`include "utf8_string_validator_assert.svh"

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   usv_cfg_type cfg;

   logic                   s1_valid_ff, s1_valid_in;
   logic [BYTE_WIDTH-1:0]  s1_byte_ff;
   logic                   s1_last_ff;

   logic [1:0]             pend_ff, pend_in;
   logic [CP_WIDTH-1:0]    cp_ff, cp_in;
   usv_class_type          class_ff, class_in;
   logic                   error_ff, error_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff;
   logic [LEN_WIDTH-1:0]   rsp_len_ff;

   logic                   advance;
   logic                   finish;
   logic [COUNT_WIDTH-1:0] count_next;
   logic [WIDE_WIDTH-1:0]  count_wide;
   logic [1:0]             pend_dec;
   logic [CP_WIDTH-1:0]    cp_dec;
   logic [CP_WIDTH-1:0]    cp_shift;
   logic [CP_WIDTH-1:0]    cp_min;
   usv_class_type          class_dec;
   logic                   err_next;
   logic                   verdict_ok;

   usv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign advance       = s1_valid_ff & (~s1_last_ff | ~rsp_valid_ff | rsp_if.ready);
   assign finish        = advance & s1_last_ff;
   assign req_if.ready  = ~s1_valid_ff | advance;
   assign s1_valid_in   = req_if.valid | (s1_valid_ff & ~advance);
   assign rsp_valid_in  = finish | (rsp_valid_ff & ~rsp_if.ready);

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.string_valid  = rsp_ok_ff;
   assign rsp_if.string_length = rsp_len_ff;

   assign cp_shift = {cp_ff[CP_WIDTH-7:0], s1_byte_ff[5:0]};

   always_comb begin
      case (class_ff)
         CLASS_TWO:   cp_min = MIN_TWO;
         CLASS_THREE: cp_min = MIN_THREE;
         default:     cp_min = MIN_FOUR;
      endcase
   end

   always_comb begin
      count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_WIDTH'(1);
      count_wide = WIDE_WIDTH'(count_next);
      err_next   = error_ff | (count_ff == COUNT_MAX)
                 | (count_wide > WIDE_WIDTH'(cfg.max_length))
                 | (cfg.reject_controls & ((s1_byte_ff < CONTROL_HI) | (s1_byte_ff == DEL_CODE)))
                 | (cfg.reject_nul & (s1_byte_ff == '0));
      pend_dec   = pend_ff;
      cp_dec     = cp_ff;
      class_dec  = class_ff;
      if (pend_ff == 2'd0) begin
         if (s1_byte_ff < ASCII_TOP) begin
            pend_dec = 2'd0;
         end else if (s1_byte_ff >= LEAD2_LO && s1_byte_ff <= LEAD2_HI) begin
            pend_dec  = 2'd1;
            class_dec = CLASS_TWO;
            cp_dec    = CP_WIDTH'(s1_byte_ff[4:0]);
         end else if (s1_byte_ff >= LEAD3_LO && s1_byte_ff <= LEAD3_HI) begin
            pend_dec  = 2'd2;
            class_dec = CLASS_THREE;
            cp_dec    = CP_WIDTH'(s1_byte_ff[3:0]);
         end else if (s1_byte_ff >= LEAD4_LO && s1_byte_ff <= LEAD4_HI) begin
            pend_dec  = 2'd3;
            class_dec = CLASS_FOUR;
            cp_dec    = CP_WIDTH'(s1_byte_ff[2:0]);
         end else begin
            err_next = 1'b1;
         end
      end else if (s1_byte_ff[7:6] != 2'b10) begin
         err_next = 1'b1;
         pend_dec = 2'd0;
         cp_dec   = '0;
      end else begin
         pend_dec = pend_ff - 2'd1;
         cp_dec   = cp_shift;
         if (pend_ff == 2'd1) begin
            cp_dec = '0;
            if ((cp_shift < cp_min) || (cp_shift > CP_MAX)
                || ((cp_shift >= SURROGATE_LO) && (cp_shift <= SURROGATE_HI))) begin
               err_next = 1'b1;
            end
         end
      end
      verdict_ok = ~err_next & (pend_dec == 2'd0);
   end

   always_comb begin
      pend_in  = pend_ff;
      cp_in    = cp_ff;
      class_in = class_ff;
      error_in = error_ff;
      count_in = count_ff;
      if (advance) begin
         if (s1_last_ff) begin
            pend_in  = 2'd0;
            cp_in    = '0;
            class_in = CLASS_TWO;
            error_in = 1'b0;
            count_in = '0;
         end else begin
            pend_in  = pend_dec;
            cp_in    = cp_dec;
            class_in = class_dec;
            error_in = err_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 2'd0;
         cp_ff        <= '0;
         class_ff     <= CLASS_TWO;
         error_ff     <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         cp_ff        <= cp_in;
         class_ff     <= class_in;
         error_ff     <= error_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         s1_byte_ff <= req_if.data_byte;
         s1_last_ff <= req_if.last_byte;
      end
      if (finish) begin
         rsp_ok_ff  <= verdict_ok;
         rsp_len_ff <= count_wide[LEN_WIDTH-1:0];
      end
   end

   `USV_ASSERT_NEXT(a_clear_after_last, clock, reset, finish,
      (count_ff == '0) && (pend_ff == 2'd0) && !error_ff, "string state not cleared")
   `USV_ASSERT_SAME(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff),
      $past(finish), "verdict without a last byte")
   `USV_ASSERT_SAME(a_len_nonzero, clock, reset, rsp_valid_ff,
      rsp_len_ff != '0, "verdict with zero length")
   `USV_ASSERT_NEXT(a_stage_hold, clock, reset, s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_last_ff), "stalled byte lost")

endmodule

`default_nettype wire

// ===== test/utf8_verdict_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// UTF-8 validator verdict checker
// Watches the byte channel, the verdict channel and register writes of the
// validator, keeps its own decoder state and policy copy, and compares each
// verdict transaction with the oldest predicted one.
// ---------------------------------------------------------------------------

module utf8_verdict_checker (
   input  logic                           clock,
   input  logic                           reset,
   usv_req_if                             req_mon,
   usv_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [usv_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [usv_pkg::DATA_WIDTH-1:0] pwdata,
   output int                             failures,
   output int                             strings_checked,
   output int                             valid_strings,
   output int                             expected_left
);
   import usv_pkg::*;

   typedef struct packed {
      logic                 string_valid;
      logic [LEN_WIDTH-1:0] string_length;
   } verdict_rec_type;

   localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

   logic                   reject_controls;
   logic                   reject_nul;
   logic [LEN_WIDTH-1:0]   max_length;

   logic [1:0]             cont_left;
   logic [CP_WIDTH-1:0]    code_point;
   usv_class_type          form;
   logic                   string_bad;
   logic [COUNT_WIDTH-1:0] byte_count;

   verdict_rec_type        expected_verdicts[$];
   verdict_rec_type        want;

   task automatic clear_string();
      cont_left  = 2'd0;
      code_point = '0;
      form       = CLASS_TWO;
      string_bad = 1'b0;
      byte_count = '0;
   endtask

   task automatic judge_byte(input logic [BYTE_WIDTH-1:0] b, input logic last);
      logic [CP_WIDTH-1:0] floor_cp;
      if (byte_count == COUNT_TOP) begin
         string_bad = 1'b1;
      end else begin
         byte_count = byte_count + 1'b1;
      end
      if (byte_count > max_length) string_bad = 1'b1;
      if (reject_controls && (b < CONTROL_HI || b == DEL_CODE)) string_bad = 1'b1;
      if (reject_nul && b == '0) string_bad = 1'b1;

      if (cont_left == 2'd0) begin
         if (b >= ASCII_TOP) begin
            if (b >= LEAD2_LO && b <= LEAD2_HI) begin
               cont_left  = 2'd1;
               form       = CLASS_TWO;
               code_point = CP_WIDTH'(b[4:0]);
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
               cont_left  = 2'd2;
               form       = CLASS_THREE;
               code_point = CP_WIDTH'(b[3:0]);
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
               cont_left  = 2'd3;
               form       = CLASS_FOUR;
               code_point = CP_WIDTH'(b[2:0]);
            end else begin
               string_bad = 1'b1;
            end
         end
      end else if (b[7:6] != 2'b10) begin
         // The open sequence is dropped and this byte is not decoded again.
         string_bad = 1'b1;
         cont_left  = 2'd0;
         code_point = '0;
      end else begin
         code_point = {code_point[CP_WIDTH-7:0], b[5:0]};
         cont_left  = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            case (form)
               CLASS_TWO:   floor_cp = MIN_TWO;
               CLASS_THREE: floor_cp = MIN_THREE;
               default:     floor_cp = MIN_FOUR;
            endcase
            if (code_point < floor_cp || code_point > CP_MAX ||
                (code_point >= SURROGATE_LO && code_point <= SURROGATE_HI)) begin
               string_bad = 1'b1;
            end
            code_point = '0;
         end
      end

      if (last) begin
         if (cont_left != 2'd0) string_bad = 1'b1;
         expected_verdicts.push_back('{string_valid: !string_bad,
                                       string_length: byte_count[LEN_WIDTH-1:0]});
         clear_string();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reject_controls = 1'b0;
         reject_nul      = 1'b0;
         max_length      = MAX_LENGTH_RESET;
         clear_string();
         expected_verdicts.delete();
         failures        = 0;
         strings_checked = 0;
         valid_strings   = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (usv_reg_type'(paddr[ADDR_WIDTH-1:2]))
               REG_REJECT_CONTROLS: reject_controls = pwdata[0];
               REG_REJECT_NUL:      reject_nul      = pwdata[0];
               REG_MAX_LENGTH:      max_length      = pwdata[LEN_WIDTH-1:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            judge_byte(req_mon.data_byte, req_mon.last_byte);
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            strings_checked++;
            if (expected_verdicts.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("ERROR: verdict with no finished string: valid=%0b length=%0d",
                           rsp_mon.string_valid, rsp_mon.string_length);
               end
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_mon.string_valid !== want.string_valid ||
                   rsp_mon.string_length !== want.string_length) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("ERROR: string %0d: expected valid=%0b length=%0d,",
                              strings_checked, want.string_valid, want.string_length);
                     $display("       got valid=%0b length=%0d",
                              rsp_mon.string_valid, rsp_mon.string_length);
                  end
               end
               if (rsp_mon.string_valid === 1'b1) valid_strings++;
            end
         end
      end
      expected_left = expected_verdicts.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// UTF-8 validator testbench
// Drives byte strings into the validator in random bursts (one phase has no gaps)
// while the verdict side stalls on its own pattern, steps through several policy
// settings and takes the verdict from the checker beside the block.
// ---------------------------------------------------------------------------

module tb_top;
   import usv_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_BYTES   = 215;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [ADDR_WIDTH-1:0] paddr;
   logic [DATA_WIDTH-1:0] pwdata;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;

   usv_req_if req_bus ();
   usv_rsp_if rsp_bus ();

   int failures;
   int strings_checked;
   int valid_strings;
   int expected_left;

   int strings_sent;
   int bytes_sent;
   int settings_used;
   int burst_left;
   int cycle_count;
   bit gaps_on;
   bit hold_req;
   bit hold_done;

   logic [BYTE_WIDTH-1:0] text_q[$];

   utf8_string_validator dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   utf8_verdict_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .failures        (failures),
      .strings_checked (strings_checked),
      .valid_strings   (valid_strings),
      .expected_left   (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d verdicts outstanding",
                  cycle_count, strings_sent - strings_checked);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(input usv_reg_type idx, input logic [DATA_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_WIDTH'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_policy(input logic controls, input logic nul,
                             input logic [LEN_WIDTH-1:0] limit);
      write_reg(REG_REJECT_CONTROLS, DATA_WIDTH'(controls));
      write_reg(REG_REJECT_NUL, DATA_WIDTH'(nul));
      write_reg(REG_MAX_LENGTH, DATA_WIDTH'(limit));
      settings_used++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (strings_checked != strings_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_byte(input logic [BYTE_WIDTH-1:0] value, input logic last);
      if (gaps_on && burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text();
      strings_sent++;
      foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
   endtask

   function automatic logic [BYTE_WIDTH-1:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   function automatic logic [20:0] random_code_point();
      logic [20:0] cp;
      int          pick;
      case ($urandom_range(0, 3))
         0: begin
            if ($urandom_range(0, 3) == 0) begin
               pick = $urandom_range(0, 32);
               cp = (pick == 32) ? 21'h7f : 21'(pick);
            end else begin
               cp = 21'($urandom_range(8'h20, 8'h7e));
            end
         end
         1: cp = 21'($urandom_range(21'h80, 21'h7ff));
         2: begin
            cp = 21'($urandom_range(21'h800, 21'hffff));
            if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp + 21'h800;
         end
         default: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
      endcase
      return cp;
   endfunction

   task automatic append_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         text_q.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
         text_q.push_back({3'b110, cp[10:6]});
         text_q.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         text_q.push_back({4'b1110, cp[15:12]});
         text_q.push_back({2'b10, cp[11:6]});
         text_q.push_back({2'b10, cp[5:0]});
      end else begin
         text_q.push_back({5'b11110, cp[20:18]});
         text_q.push_back({2'b10, cp[17:12]});
         text_q.push_back({2'b10, cp[11:6]});
         text_q.push_back({2'b10, cp[5:0]});
      end
   endtask

   task automatic damage_text();
      logic [BYTE_WIDTH-1:0] bad_q[$];
      int                    spot;
      spot = $urandom_range(0, text_q.size());
      case ($urandom_range(0, 6))
         0: begin
            case ($urandom_range(0, 2))
               0:       bad_q = '{8'hc3};
               1:       bad_q = '{8'he2, 8'h82};
               default: bad_q = '{8'hf0, 8'h9f, 8'h98};
            endcase
            spot = text_q.size();
         end
         1: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
         2: bad_q = '{cont_byte()};
         3: begin
            case ($urandom_range(0, 2))
               0: bad_q = '{8'hc0 + 8'($urandom_range(0, 1)), cont_byte()};
               1: bad_q = '{8'he0, 8'h80 + 8'($urandom_range(0, 31)), cont_byte()};
               default: bad_q = '{8'hf0, 8'h80 + 8'($urandom_range(0, 15)),
                                  cont_byte(), cont_byte()};
            endcase
         end
         4: bad_q = '{8'hed, 8'ha0 + 8'($urandom_range(0, 31)), cont_byte()};
         5: begin
            if ($urandom_range(0, 1) == 0) begin
               bad_q = '{8'hf4, 8'h90 + 8'($urandom_range(0, 47)), cont_byte(), cont_byte()};
            end else begin
               bad_q = '{8'hf5 + 8'($urandom_range(0, 10))};
            end
         end
         default: bad_q = '{8'hc2 + 8'($urandom_range(0, 29)),
                            8'h20 + 8'($urandom_range(0, 95))};
      endcase
      foreach (bad_q[i]) text_q.insert(spot + i, bad_q[i]);
   endtask

   task automatic make_random_text();
      int pick;
      text_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) append_code_point(random_code_point());
         if (pick >= 75) damage_text();
      end
   endtask

   task automatic random_phase();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
         make_random_text();
         send_text();
      end
      wait_idle();
   endtask

   initial begin : rsp_stall_pattern
      int seg;
      int mode;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end
         seg  = $urandom_range(4, 40);
         mode = $urandom_range(0, 3);
         repeat (seg) begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      strings_sent      = 0;
      bytes_sent        = 0;
      settings_used     = 1;
      burst_left        = 0;
      gaps_on           = 1'b1;
      hold_req          = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset policy: boundary lead bytes, overlong, surrogate, out of range,
      // truncated and broken sequences.
      text_q = '{8'h00};                      send_text();
      text_q = '{8'hff};                      send_text();
      text_q = '{8'hc2, 8'h80};               send_text();
      text_q = '{8'hc1, 8'hbf};               send_text();
      text_q = '{8'he0, 8'h9f, 8'hbf};        send_text();
      text_q = '{8'hed, 8'ha0, 8'h80};        send_text();
      text_q = '{8'hf4, 8'h8f, 8'hbf, 8'hbf}; send_text();
      text_q = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_text();
      text_q = '{8'he2, 8'h82};               send_text();
      text_q = '{8'hc3, 8'h41};               send_text();
      text_q = '{8'h80};                      send_text();
      wait_idle();

      set_policy(1'b1, 1'b1, LEN_WIDTH'(1));
      text_q = '{8'h00};        send_text();
      text_q = '{8'h1f};        send_text();
      text_q = '{8'h7f};        send_text();
      text_q = '{8'h41};        send_text();
      text_q = '{8'h41, 8'h42}; send_text();
      wait_idle();

      set_policy(1'b0, 1'b0, LEN_WIDTH'(0));
      text_q = '{8'h41}; send_text();
      wait_idle();

      set_policy(1'b0, 1'b0, MAX_LENGTH_RESET);
      random_phase();

      set_policy(1'b1, 1'b1, LEN_WIDTH'(16));
      hold_req = 1'b1;
      random_phase();

      set_policy(1'b1, 1'b0, LEN_WIDTH'(5));
      gaps_on = 1'b0;
      random_phase();
      gaps_on = 1'b1;

      set_policy(1'b0, 1'b1, '1);
      random_phase();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bytes in %0d strings under %0d policy settings;",
               bytes_sent, strings_sent, settings_used);
      $display("%0d verdicts checked, %0d valid, covering lead and continuation limits,",
               strings_checked, valid_strings);
      $display("overlong, surrogate, range, truncation and byte and length policies.");
      if (failures == 0 && expected_left == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
